/* rtl/ocprw_pkg.sv */
// ocprw_pkg: shared types, action and command codes for the display RAM writer.
// No dependencies; the parser, top level and bench refer to it by scoped names.
`timescale 1ns / 1ps

package ocprw_pkg;

	localparam int PTR_W  = 8;
	localparam int BYTE_W = 8;

	// action codes carried on tuser
	localparam logic [1:0] ACT_CMD   = 2'd0;
	localparam logic [1:0] ACT_DATA  = 2'd1;
	localparam logic [1:0] ACT_READ  = 2'd2;
	localparam logic [1:0] ACT_RESET = 2'd3;

	// commands that act on the parser state
	localparam logic [7:0] CMD_ADDR_MODE = 8'h20;
	localparam logic [7:0] CMD_COL_WIN   = 8'h21;
	localparam logic [7:0] CMD_PAGE_WIN  = 8'h22;

	// commands whose arguments are swallowed
	localparam logic [7:0] CMD_CONTRAST    = 8'h81;
	localparam logic [7:0] CMD_BANK0       = 8'h82;
	localparam logic [7:0] CMD_MUX_RATIO   = 8'hA8;
	localparam logic [7:0] CMD_MASTER_CFG  = 8'hAD;
	localparam logic [7:0] CMD_DISP_OFFSET = 8'hD3;
	localparam logic [7:0] CMD_CLK_DIV     = 8'hD5;
	localparam logic [7:0] CMD_AREA_COLOUR = 8'hD8;
	localparam logic [7:0] CMD_PRECHARGE   = 8'hD9;
	localparam logic [7:0] CMD_COM_PINS    = 8'hDA;
	localparam logic [7:0] CMD_VCOMH       = 8'hDB;
	localparam logic [7:0] CMD_LUT         = 8'h91;
	localparam logic [7:0] CMD_BANK_COL_A  = 8'h92;
	localparam logic [7:0] CMD_BANK_COL_B  = 8'h93;
	localparam logic [7:0] CMD_DIM_MODE    = 8'hAB;

	typedef struct packed {
		logic [PTR_W-1:0] column;
		logic [PTR_W-1:0] page;
	} ptr_t;

	typedef struct packed {
		logic              en;
		logic [PTR_W-1:0]  column;
		logic [PTR_W-1:0]  page;
		logic [BYTE_W-1:0] data;
	} wreq_t;

	function automatic logic [2:0] arg_count(input logic [7:0] cmd);
		logic [2:0] n;
		n = 3'd0;
		if (cmd == CMD_ADDR_MODE) begin
			n = 3'd1;
		end else if (cmd == CMD_COL_WIN || cmd == CMD_PAGE_WIN) begin
			n = 3'd2;
		end else if (cmd inside {CMD_CONTRAST, CMD_BANK0, CMD_MUX_RATIO, CMD_MASTER_CFG,
				CMD_DISP_OFFSET, CMD_CLK_DIV, CMD_AREA_COLOUR, CMD_PRECHARGE,
				CMD_COM_PINS, CMD_VCOMH}) begin
			n = 3'd1;
		end else if (cmd inside {CMD_LUT, CMD_BANK_COL_A, CMD_BANK_COL_B}) begin
			n = 3'd4;
		end else if (cmd == CMD_DIM_MODE) begin
			n = 3'd3;
		end
		return n;
	endfunction

endpackage

/* rtl/ocprw_ram.sv */
// ocprw_ram: generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
`timescale 1ns / 1ps

module ocprw_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

/* rtl/ocprw_parser.sv */
// ocprw_parser: command parser, window registers and write pointer.
// Depends on ocprw_pkg.
`timescale 1ns / 1ps

module ocprw_parser #(
	parameter int COLUMNS = 128,
	parameter int PAGES   = 8
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                step,
	input  logic [1:0]          action,
	input  logic [7:0]          data_byte,
	output ocprw_pkg::ptr_t     ptr,
	output ocprw_pkg::wreq_t    wreq
);

	localparam logic [7:0] LAST_COL  = 8'(COLUMNS - 1);
	localparam logic [7:0] LAST_PAGE = 8'(PAGES - 1);

	logic [1:0] vmode_q, vmode_d;
	logic [7:0] fcol_q, fcol_d, lcol_q, lcol_d;
	logic [7:0] fpage_q, fpage_d, lpage_q, lpage_d;
	logic [7:0] wcol_q, wcol_d, wpage_q, wpage_d;
	logic [7:0] pend_q, pend_d;
	logic [2:0] args_q, args_d;
	logic [2:0] n_args;
	ocprw_pkg::ptr_t adv;

	// one step through the window; the inner axis wraps first
	function automatic ocprw_pkg::ptr_t advance(
		input logic [1:0] vm,
		input logic [7:0] col, input logic [7:0] pg,
		input logic [7:0] fc, input logic [7:0] lc,
		input logic [7:0] fp, input logic [7:0] lp
	);
		ocprw_pkg::ptr_t r;
		logic [8:0] c1, p1;
		c1 = {1'b0, col} + 9'd1;
		p1 = {1'b0, pg} + 9'd1;
		r.column = col;
		r.page   = pg;
		if (vm == 2'd0) begin
			if (c1 > {1'b0, lc}) begin
				r.column = fc;
				r.page   = (p1 > {1'b0, lp}) ? fp : p1[7:0];
			end else begin
				r.column = c1[7:0];
			end
		end else begin
			if (p1 > {1'b0, lp}) begin
				r.page   = fp;
				r.column = (c1 > {1'b0, lc}) ? fc : c1[7:0];
			end else begin
				r.page = p1[7:0];
			end
		end
		return r;
	endfunction

	assign n_args = ocprw_pkg::arg_count(data_byte);
	assign adv = advance(vmode_q, wcol_q, wpage_q, fcol_q, lcol_q, fpage_q, lpage_q);

	always_comb begin
		vmode_d = vmode_q;
		fcol_d  = fcol_q;
		lcol_d  = lcol_q;
		fpage_d = fpage_q;
		lpage_d = lpage_q;
		wcol_d  = wcol_q;
		wpage_d = wpage_q;
		pend_d  = pend_q;
		args_d  = args_q;
		if (step) begin
			case (action)
				ocprw_pkg::ACT_CMD: begin
					if (args_q != 3'd0) begin
						if (pend_q == ocprw_pkg::CMD_ADDR_MODE) begin
							vmode_d = data_byte[1:0];
						end else if (pend_q == ocprw_pkg::CMD_COL_WIN) begin
							if (args_q == 3'd2) fcol_d = data_byte;
							else lcol_d = data_byte;
						end else if (pend_q == ocprw_pkg::CMD_PAGE_WIN) begin
							if (args_q == 3'd2) fpage_d = data_byte;
							else lpage_d = data_byte;
						end
						args_d = args_q - 3'd1;
						// last argument: pointer home
						if (args_q == 3'd1) begin
							wcol_d  = fcol_d;
							wpage_d = fpage_d;
						end
					end else if (n_args != 3'd0) begin
						pend_d = data_byte;
						args_d = n_args;
					end
				end
				ocprw_pkg::ACT_DATA: begin
					wcol_d  = adv.column;
					wpage_d = adv.page;
				end
				ocprw_pkg::ACT_RESET: begin
					vmode_d = 2'd0;
					fcol_d  = 8'd0;
					lcol_d  = LAST_COL;
					fpage_d = 8'd0;
					lpage_d = LAST_PAGE;
					wcol_d  = 8'd0;
					wpage_d = 8'd0;
					pend_d  = 8'd0;
					args_d  = 3'd0;
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vmode_q <= 2'd0;
			fcol_q  <= 8'd0;
			lcol_q  <= LAST_COL;
			fpage_q <= 8'd0;
			lpage_q <= LAST_PAGE;
			wcol_q  <= 8'd0;
			wpage_q <= 8'd0;
			pend_q  <= 8'd0;
			args_q  <= 3'd0;
		end else begin
			vmode_q <= vmode_d;
			fcol_q  <= fcol_d;
			lcol_q  <= lcol_d;
			fpage_q <= fpage_d;
			lpage_q <= lpage_d;
			wcol_q  <= wcol_d;
			wpage_q <= wpage_d;
			pend_q  <= pend_d;
			args_q  <= args_d;
		end
	end

	assign ptr.column  = wcol_d;
	assign ptr.page    = wpage_d;
	assign wreq.en     = step && (action == ocprw_pkg::ACT_DATA);
	assign wreq.column = wcol_q;
	assign wreq.page   = wpage_q;
	assign wreq.data   = data_byte;

	// a data word never moves the window or the parser
	assert property (@(posedge clk) disable iff (!arst_n)
		step && action == ocprw_pkg::ACT_DATA |=> $stable(args_q) && $stable(fcol_q))
		else $error("data word disturbed parser state");

endmodule

/* rtl/oled_command_parser_and_ram_writer_top.sv */
// Display RAM writer top level: stream handshake, clearing sweep and display RAM.
// Depends on ocprw_pkg, ocprw_parser and ocprw_ram.
`timescale 1ns / 1ps

// Usage:
// Input words arrive on s_axis; tuser carries the action (command, data, read,
// reset), tdata the byte and the read address. Each word gives exactly one
// result word on m_axis: read data (zero unless a read) and the write pointer.
// Result path: command, data and reset words show their result in the cycle after
// acceptance; a read word passes the registered RAM read port, then the output register.
// Throughput: one word a cycle while the output is taken and no sweep runs, except a
// read, which holds the input off while the RAM answers.
// Reset: after arst_n and after a reset word, a sweep writes zero to all
// COLUMNS*PAGES RAM locations, one a cycle; s_axis_tready is low for the sweep.
// The result of the reset word is offered meanwhile.
// Stall: the result sits in the output register while m_axis_tready is low; a new
// word is taken in the cycle the pending result leaves.
module oled_command_parser_and_ram_writer_top #(
	parameter int COLUMNS = 128,
	parameter int PAGES   = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [23:0] s_axis_tdata,  // data_byte[7:0], read_page[10:8], read_column[17:11], zero
	input  logic [1:0]  s_axis_tuser,  // action[1:0]
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [23:0] m_axis_tdata   // read_data[7:0], column_pointer[15:8], page_pointer[23:16]
);

	localparam int DEPTH = COLUMNS * PAGES;
	localparam int AW    = $clog2(DEPTH);

	localparam logic [1:0] ST_CLEAR = 2'd0;
	localparam logic [1:0] ST_IDLE  = 2'd1;
	localparam logic [1:0] ST_READ  = 2'd2;

	logic [1:0]    state_q;
	logic [AW-1:0] clr_addr_q;
	logic          out_valid_q;
	logic [23:0]   out_data_q;
	logic          rd_ok_s1;

	logic          in_acc;
	logic [1:0]    action;
	logic [7:0]    data_byte;
	logic [2:0]    read_page;
	logic [6:0]    read_column;
	logic          rd_ok;

	ocprw_pkg::ptr_t  ptr;
	ocprw_pkg::wreq_t wreq;

	logic          wr_ok;
	logic          ram_we;
	logic [AW-1:0] ram_waddr;
	logic [7:0]    ram_wdata;
	logic [AW-1:0] ram_raddr;
	logic [7:0]    ram_rdata;

	assign action      = s_axis_tuser;
	assign data_byte   = s_axis_tdata[7:0];
	assign read_page   = s_axis_tdata[10:8];
	assign read_column = s_axis_tdata[17:11];

	assign s_axis_tready = (state_q == ST_IDLE) && (!out_valid_q || m_axis_tready);
	assign in_acc        = s_axis_tvalid && s_axis_tready;

	ocprw_parser #(
		.COLUMNS(COLUMNS),
		.PAGES  (PAGES)
	) u_parser (
		.clk      (clk),
		.arst_n   (arst_n),
		.step     (in_acc),
		.action   (action),
		.data_byte(data_byte),
		.ptr      (ptr),
		.wreq     (wreq)
	);

	// out-of-range pointers drop the data word
	assign wr_ok = (32'(wreq.page) < PAGES) && (32'(wreq.column) < COLUMNS);
	assign rd_ok = (32'(read_page) < PAGES) && (32'(read_column) < COLUMNS);

	always_comb begin
		if (state_q == ST_CLEAR) begin
			ram_we    = 1'b1;
			ram_waddr = clr_addr_q;
			ram_wdata = 8'd0;
		end else begin
			ram_we    = wreq.en && wr_ok;
			ram_waddr = AW'(32'(wreq.page) * 32'(COLUMNS) + 32'(wreq.column));
			ram_wdata = wreq.data;
		end
	end

	assign ram_raddr = AW'(32'(read_page) * 32'(COLUMNS) + 32'(read_column));

	ocprw_ram #(
		.WIDTH(8),
		.DEPTH(DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk) begin
		if (in_acc) begin
			rd_ok_s1 <= rd_ok;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_CLEAR;
			clr_addr_q <= '0;
		end else begin
			case (state_q)
				ST_CLEAR: begin
					clr_addr_q <= clr_addr_q + AW'(1);
					if (clr_addr_q == AW'(DEPTH - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (in_acc && action == ocprw_pkg::ACT_READ) begin
						state_q <= ST_READ;
					end else if (in_acc && action == ocprw_pkg::ACT_RESET) begin
						state_q    <= ST_CLEAR;
						clr_addr_q <= '0;
					end
				end
				ST_READ: begin
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (in_acc && action != ocprw_pkg::ACT_READ) begin
			out_valid_q <= 1'b1;
		end else if (state_q == ST_READ) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc && action != ocprw_pkg::ACT_READ) begin
			out_data_q <= {ptr.page, ptr.column, 8'd0};
		end else if (state_q == ST_READ) begin
			out_data_q <= {ptr.page, ptr.column, rd_ok_s1 ? ram_rdata : 8'd0};
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;

	// the output register is always free when the RAM answer lands
	assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_READ |-> !out_valid_q)
		else $error("read result would overwrite a pending word");

	assert property (@(posedge clk) disable iff (!arst_n)
		in_acc && action == ocprw_pkg::ACT_RESET |=> state_q == ST_CLEAR && clr_addr_q == '0)
		else $error("reset word did not start the clearing sweep");

	assert property (@(posedge clk) disable iff (!arst_n)
		in_acc && action == ocprw_pkg::ACT_READ |-> ##2 out_valid_q)
		else $error("read word produced no result");

	assert property (@(posedge clk) disable iff (!arst_n)
		ram_we && state_q != ST_CLEAR |-> in_acc && action == ocprw_pkg::ACT_DATA)
		else $error("RAM written outside a data word or the sweep");

endmodule

/* tb/oled_command_parser_and_ram_writer_top_tb.sv */
// Self-checking bench for the display RAM writer: streams command, data, read and reset
// words and checks every result word against a shadow of the RAM, window and pointer.
// Depends on ocprw_pkg and oled_command_parser_and_ram_writer_top.
`timescale 1ns / 1ps

module oled_command_parser_and_ram_writer_top_tb;

	localparam int NCOL        = 128;
	localparam int NPAGE       = 8;
	localparam int CYCLE_LIMIT = 500000;

	typedef struct packed {
		logic [1:0] action;
		logic [7:0] data_byte;
		logic [2:0] read_page;
		logic [6:0] read_column;
		logic       hold_until_empty;	// sender waits for all results first
	} word_t;

	typedef struct packed {
		logic [7:0] read_data;
		logic [7:0] column_pointer;
		logic [7:0] page_pointer;
	} reply_t;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [23:0] s_axis_tdata;	// data_byte[7:0], read_page[10:8], read_column[17:11], zero
	logic [1:0]  s_axis_tuser;	// action[1:0]
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [23:0] m_axis_tdata;	// read_data[7:0], column_pointer[15:8], page_pointer[23:16]

	oled_command_parser_and_ram_writer_top #(
		.COLUMNS(NCOL),
		.PAGES  (NPAGE)
	) dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tuser (s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata)
	);

	always #5 clk = ~clk;

	initial begin
		arst_n = 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
	end

	// shadow of the display state
	logic [7:0]  shadow_ram [NCOL*NPAGE];
	logic [1:0]  scan_mode;
	int unsigned col_first, col_last, page_first, page_last;
	int unsigned col_ptr, pg_ptr;
	logic [7:0]  arg_cmd;
	logic [2:0]  args_left;

	word_t  send_q[$];
	reply_t replies_due[$];
	word_t  in_flight;
	reply_t want;
	int     gap_left, stall_left, hold;
	int     words_sent, results_seen, failures, cycle_count;
	int     act_seen[4];

	function automatic logic [2:0] args_taken(input logic [7:0] cmd);
		case (cmd)
			ocprw_pkg::CMD_ADDR_MODE: return 3'd1;
			ocprw_pkg::CMD_COL_WIN, ocprw_pkg::CMD_PAGE_WIN: return 3'd2;
			ocprw_pkg::CMD_CONTRAST, ocprw_pkg::CMD_BANK0, ocprw_pkg::CMD_MUX_RATIO,
			ocprw_pkg::CMD_MASTER_CFG, ocprw_pkg::CMD_DISP_OFFSET, ocprw_pkg::CMD_CLK_DIV,
			ocprw_pkg::CMD_AREA_COLOUR, ocprw_pkg::CMD_PRECHARGE, ocprw_pkg::CMD_COM_PINS,
			ocprw_pkg::CMD_VCOMH: return 3'd1;
			ocprw_pkg::CMD_LUT, ocprw_pkg::CMD_BANK_COL_A,
			ocprw_pkg::CMD_BANK_COL_B: return 3'd4;
			ocprw_pkg::CMD_DIM_MODE: return 3'd3;
			default: return 3'd0;
		endcase
	endfunction

	function automatic logic [7:0] swallowing_cmd(input int i);
		case (i)
			0: return ocprw_pkg::CMD_CONTRAST;
			1: return ocprw_pkg::CMD_BANK0;
			2: return ocprw_pkg::CMD_MUX_RATIO;
			3: return ocprw_pkg::CMD_MASTER_CFG;
			4: return ocprw_pkg::CMD_DISP_OFFSET;
			5: return ocprw_pkg::CMD_CLK_DIV;
			6: return ocprw_pkg::CMD_AREA_COLOUR;
			7: return ocprw_pkg::CMD_PRECHARGE;
			8: return ocprw_pkg::CMD_COM_PINS;
			9: return ocprw_pkg::CMD_VCOMH;
			10: return ocprw_pkg::CMD_LUT;
			11: return ocprw_pkg::CMD_BANK_COL_A;
			12: return ocprw_pkg::CMD_BANK_COL_B;
			default: return ocprw_pkg::CMD_DIM_MODE;
		endcase
	endfunction

	function automatic void shadow_reset();
		for (int i = 0; i < NCOL*NPAGE; i++)
			shadow_ram[i] = 8'd0;
		scan_mode  = 2'd0;
		col_first  = 0;
		col_last   = NCOL - 1;
		page_first = 0;
		page_last  = NPAGE - 1;
		arg_cmd    = 8'd0;
		args_left  = 3'd0;
		col_ptr    = 0;
		pg_ptr     = 0;
	endfunction

	// pointers are kept wider than 8 bits so a step past 255 still wraps to the window start
	function automatic void step_pointer();
		if (scan_mode == 2'd0) begin
			col_ptr++;
			if (col_ptr > col_last) begin
				col_ptr = col_first;
				pg_ptr++;
				if (pg_ptr > page_last)
					pg_ptr = page_first;
			end
		end else begin
			pg_ptr++;
			if (pg_ptr > page_last) begin
				pg_ptr = page_first;
				col_ptr++;
				if (col_ptr > col_last)
					col_ptr = col_first;
			end
		end
	endfunction

	function automatic void take_cmd_byte(input logic [7:0] b);
		if (args_left != 3'd0) begin
			if (arg_cmd == ocprw_pkg::CMD_ADDR_MODE) begin
				scan_mode = b[1:0];
			end else if (arg_cmd == ocprw_pkg::CMD_COL_WIN) begin
				if (args_left == 3'd2)
					col_first = 32'(b);
				else
					col_last = 32'(b);
			end else if (arg_cmd == ocprw_pkg::CMD_PAGE_WIN) begin
				if (args_left == 3'd2)
					page_first = 32'(b);
				else
					page_last = 32'(b);
			end
			args_left--;
			if (args_left == 3'd0) begin
				col_ptr = col_first;
				pg_ptr  = page_first;
			end
		end else if (args_taken(b) != 3'd0) begin
			arg_cmd   = b;
			args_left = args_taken(b);
		end
	endfunction

	function automatic reply_t compute_reply(input word_t w);
		reply_t r;
		r.read_data = 8'd0;
		case (w.action)
			ocprw_pkg::ACT_CMD: take_cmd_byte(w.data_byte);
			ocprw_pkg::ACT_DATA: begin
				if (pg_ptr < NPAGE && col_ptr < NCOL)
					shadow_ram[pg_ptr*NCOL + col_ptr] = w.data_byte;
				step_pointer();
			end
			ocprw_pkg::ACT_READ: begin
				if (w.read_page < NPAGE && w.read_column < NCOL)
					r.read_data = shadow_ram[w.read_page*NCOL + w.read_column];
			end
			ocprw_pkg::ACT_RESET: shadow_reset();
			default: ;
		endcase
		r.column_pointer = col_ptr[7:0];
		r.page_pointer   = pg_ptr[7:0];
		return r;
	endfunction

	function automatic void add_word(input int unsigned act, input int unsigned b,
			input int unsigned pg, input int unsigned cl, input bit hold_first);
		word_t w;
		w.action           = 2'(act);
		w.data_byte        = 8'(b);
		w.read_page        = 3'(pg);
		w.read_column      = 7'(cl);
		w.hold_until_empty = hold_first;
		send_q.push_back(w);
	endfunction

	// driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
			s_axis_tdata  <= '0;
			s_axis_tuser  <= ocprw_pkg::ACT_CMD;
			gap_left      <= 0;
		end else begin
			if (s_axis_tvalid && s_axis_tready) begin
				replies_due.push_back(compute_reply(in_flight));
				act_seen[in_flight.action]++;
				words_sent++;
			end
			if (!s_axis_tvalid || s_axis_tready) begin
				if (gap_left > 0) begin
					gap_left      <= gap_left - 1;
					s_axis_tvalid <= 1'b0;
				end else if (send_q.size() > 0 &&
						!(send_q[0].hold_until_empty && replies_due.size() > 0)) begin
					in_flight = send_q.pop_front();
					s_axis_tvalid <= 1'b1;
					s_axis_tuser  <= in_flight.action;
					s_axis_tdata  <= {6'd0, in_flight.read_column, in_flight.read_page,
						in_flight.data_byte};
					// every 250 words, a run of 50 back to back
					gap_left      <= (words_sent % 250 >= 200) ? 0 : $urandom_range(0, 6);
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
		end
	end

	// monitor and checker
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
			stall_left    <= 0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				results_seen++;
				if (replies_due.size() == 0) begin
					$error("result word %h with nothing expected", m_axis_tdata);
					failures++;
				end else begin
					want = replies_due.pop_front();
					if (m_axis_tdata[7:0] !== want.read_data) begin
						$error("read_data: expected %0d, got %0d", want.read_data,
							m_axis_tdata[7:0]);
						failures++;
					end
					if (m_axis_tdata[15:8] !== want.column_pointer) begin
						$error("column_pointer: expected %0d, got %0d",
							want.column_pointer, m_axis_tdata[15:8]);
						failures++;
					end
					if (m_axis_tdata[23:16] !== want.page_pointer) begin
						$error("page_pointer: expected %0d, got %0d", want.page_pointer,
							m_axis_tdata[23:16]);
						failures++;
					end
				end
				hold = (results_seen % 300 < 60) ? 0 : $urandom_range(0, 6);
				if (hold == 0) begin
					m_axis_tready <= 1'b1;
				end else begin
					m_axis_tready <= 1'b0;
					stall_left    <= hold;
				end
			end else if (stall_left > 0) begin
				stall_left    <= stall_left - 1;
				m_axis_tready <= (stall_left == 1);
			end else begin
				m_axis_tready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	initial begin
		int pick, lo, hi, n, near_col, near_page;
		logic [7:0] cmd;

		words_sent   = 0;
		results_seen = 0;
		failures     = 0;
		cycle_count  = 0;
		for (int i = 0; i < 4; i++)
			act_seen[i] = 0;
		shadow_reset();

		// directed opening
		add_word(ocprw_pkg::ACT_READ, 8'h00, 3'd7, 7'd127, 1'b0);	// cleared RAM, far corner
		add_word(ocprw_pkg::ACT_CMD, 8'h00, 3'd0, 7'd0, 1'b0);	// unknown command, ignored
		add_word(ocprw_pkg::ACT_DATA, 8'hFF, 3'd0, 7'd0, 1'b0);
		add_word(ocprw_pkg::ACT_DATA, 8'h00, 3'd7, 7'd127, 1'b0);
		add_word(ocprw_pkg::ACT_READ, 8'hFF, 3'd0, 7'd0, 1'b0);
		add_word(ocprw_pkg::ACT_CMD, ocprw_pkg::CMD_ADDR_MODE, 3'd0, 7'd0, 1'b0);
		add_word(ocprw_pkg::ACT_CMD, 8'h03, 3'd0, 7'd0, 1'b0);	// vertical
		add_word(ocprw_pkg::ACT_DATA, 8'hA5, 3'd0, 7'd0, 1'b0);
		add_word(ocprw_pkg::ACT_DATA, 8'h5A, 3'd0, 7'd0, 1'b0);
		add_word(ocprw_pkg::ACT_CMD, ocprw_pkg::CMD_COL_WIN, 3'd0, 7'd0, 1'b0);
		add_word(ocprw_pkg::ACT_DATA, 8'h3C, 3'd0, 7'd0, 1'b0);	// data with arguments pending
		add_word(ocprw_pkg::ACT_CMD, 8'hFE, 3'd0, 7'd0, 1'b0);	// window beyond the RAM
		add_word(ocprw_pkg::ACT_CMD, 8'hFF, 3'd0, 7'd0, 1'b0);
		add_word(ocprw_pkg::ACT_CMD, ocprw_pkg::CMD_ADDR_MODE, 3'd0, 7'd0, 1'b0);
		add_word(ocprw_pkg::ACT_CMD, 8'hFC, 3'd0, 7'd0, 1'b0);	// low bits zero: horizontal
		repeat (3) add_word(ocprw_pkg::ACT_DATA, 8'h81, 3'd0, 7'd0, 1'b0);	// dropped, wraps
		add_word(ocprw_pkg::ACT_CMD, ocprw_pkg::CMD_PAGE_WIN, 3'd0, 7'd0, 1'b0);
		add_word(ocprw_pkg::ACT_CMD, 8'd5, 3'd0, 7'd0, 1'b0);
		add_word(ocprw_pkg::ACT_CMD, 8'd2, 3'd0, 7'd0, 1'b0);	// start above end
		add_word(ocprw_pkg::ACT_DATA, 8'h77, 3'd0, 7'd0, 1'b0);
		add_word(ocprw_pkg::ACT_CMD, ocprw_pkg::CMD_DIM_MODE, 3'd0, 7'd0, 1'b0);
		add_word(ocprw_pkg::ACT_CMD, ocprw_pkg::CMD_COL_WIN, 3'd0, 7'd0, 1'b0);	// arguments
		add_word(ocprw_pkg::ACT_CMD, ocprw_pkg::CMD_PAGE_WIN, 3'd0, 7'd0, 1'b0);
		add_word(ocprw_pkg::ACT_CMD, ocprw_pkg::CMD_ADDR_MODE, 3'd0, 7'd0, 1'b0);
		add_word(ocprw_pkg::ACT_RESET, 8'h00, 3'd0, 7'd0, 1'b1);
		add_word(ocprw_pkg::ACT_READ, 8'h00, 3'd0, 7'd0, 1'b1);

		// random part: mostly well-formed command sequences around bursts of data
		near_col  = 0;
		near_page = 0;
		while (send_q.size() < 1680) begin
			pick = $urandom_range(0, 99);
			if (pick < 30) begin
				repeat ($urandom_range(1, 12))
					add_word(ocprw_pkg::ACT_DATA, $urandom, $urandom, $urandom, 1'b0);
			end else if (pick < 45) begin
				repeat ($urandom_range(1, 4)) begin
					if ($urandom_range(0, 1) == 1)
						add_word(ocprw_pkg::ACT_READ, $urandom, $urandom, $urandom, 1'b0);
					else
						add_word(ocprw_pkg::ACT_READ, $urandom,
							near_page + $urandom_range(0, 1),
							near_col + $urandom_range(0, 15), 1'b0);
				end
			end else if (pick < 57) begin
				n = $urandom_range(0, 9);
				if (n < 7) begin
					lo = $urandom_range(0, 127);
					hi = lo + $urandom_range(0, 15);
					if (hi > 127) hi = 127;
				end else if (n < 8) begin
					lo = $urandom_range(1, 127);
					hi = $urandom_range(0, lo - 1);
				end else begin
					lo = $urandom_range(0, 255);
					hi = $urandom_range(0, 255);
				end
				near_col = lo;
				add_word(ocprw_pkg::ACT_CMD, ocprw_pkg::CMD_COL_WIN, $urandom, $urandom, 1'b0);
				add_word(ocprw_pkg::ACT_CMD, lo, $urandom, $urandom, 1'b0);
				add_word(ocprw_pkg::ACT_CMD, hi, $urandom, $urandom, 1'b0);
			end else if (pick < 69) begin
				n = $urandom_range(0, 9);
				if (n < 7) begin
					lo = $urandom_range(0, 7);
					hi = lo + $urandom_range(0, 3);
					if (hi > 7) hi = 7;
				end else if (n < 8) begin
					lo = $urandom_range(1, 7);
					hi = $urandom_range(0, lo - 1);
				end else begin
					lo = $urandom_range(0, 15);
					hi = $urandom_range(0, 255);
				end
				near_page = lo;
				add_word(ocprw_pkg::ACT_CMD, ocprw_pkg::CMD_PAGE_WIN, $urandom, $urandom, 1'b0);
				add_word(ocprw_pkg::ACT_CMD, lo, $urandom, $urandom, 1'b0);
				add_word(ocprw_pkg::ACT_CMD, hi, $urandom, $urandom, 1'b0);
			end else if (pick < 77) begin
				add_word(ocprw_pkg::ACT_CMD, ocprw_pkg::CMD_ADDR_MODE, $urandom, $urandom,
					1'b0);
				add_word(ocprw_pkg::ACT_CMD, $urandom, $urandom, $urandom, 1'b0);
			end else if (pick < 87) begin
				cmd = swallowing_cmd($urandom_range(0, 13));
				add_word(ocprw_pkg::ACT_CMD, cmd, $urandom, $urandom, 1'b0);
				repeat (args_taken(cmd))
					add_word(ocprw_pkg::ACT_CMD, $urandom, $urandom, $urandom, 1'b0);
			end else if (pick < 92) begin
				// window command broken up by data and reads
				add_word(ocprw_pkg::ACT_CMD, ($urandom_range(0, 1) == 1) ?
					ocprw_pkg::CMD_COL_WIN : ocprw_pkg::CMD_PAGE_WIN,
					$urandom, $urandom, 1'b0);
				add_word(ocprw_pkg::ACT_CMD, $urandom_range(0, 15), $urandom, $urandom, 1'b0);
				add_word(ocprw_pkg::ACT_DATA, $urandom, $urandom, $urandom, 1'b0);
				add_word(ocprw_pkg::ACT_READ, $urandom, $urandom, $urandom, 1'b0);
				add_word(ocprw_pkg::ACT_CMD, $urandom_range(0, 127), $urandom, $urandom, 1'b0);
			end else if (pick < 98) begin
				add_word($urandom_range(0, 2), $urandom, $urandom, $urandom,
					$urandom_range(0, 3) == 0);
			end else begin
				add_word(ocprw_pkg::ACT_RESET, $urandom, $urandom, $urandom,
					$urandom_range(0, 1) == 1);
			end
		end

		wait (arst_n === 1'b1);
		while (send_q.size() > 0 || s_axis_tvalid)
			@(posedge clk);
		while (replies_due.size() > 0)
			@(posedge clk);
		repeat (10) @(posedge clk);

		$display("Drove %0d words: %0d command, %0d data, %0d read, %0d reset.",
			words_sent, act_seen[ocprw_pkg::ACT_CMD], act_seen[ocprw_pkg::ACT_DATA],
			act_seen[ocprw_pkg::ACT_READ], act_seen[ocprw_pkg::ACT_RESET]);
		$display("Checked %0d result words with random gaps and stalls; %0d mismatches.",
			results_seen, failures);
		if (failures == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule
